/* hdl/rbfplq_pkg.sv */
// Package of the RBF prototype learn and query core: item types, defaults, states, exp tables.
package rbfplq_pkg;

    localparam int BASES_DEF   = 64;
    localparam int IN_DIM_DEF  = 8;
    localparam int OUT_DIM_DEF = 4;
    localparam int MAX_OUT     = 4;
    localparam int EXP_LIMIT   = 3072;

    localparam logic [15:0] GAIN_RESET = 16'd256;
    localparam logic [15:0] RATE_RESET = 16'd6554;

    localparam logic CFG_GAIN = 1'b0;
    localparam logic CFG_RATE = 1'b1;

    typedef struct packed {
        logic               mode;
        logic               is_target;
        logic signed [15:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] result_value;
        logic [1:0]         element_index;
        logic               result_last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COPY,
        S_DIST,
        S_GAIN,
        S_EXP1,
        S_EXP2,
        S_WEIGHT,
        S_UPD_RD,
        S_UPD_WR,
        S_Q_ACC,
        S_Q_START,
        S_Q_DIV,
        S_Q_OUT
    } state_t;

    // exp(-n) for the integer part of the argument, Q1.16.
    function automatic logic [16:0] exp_int(input logic [3:0] idx);
        logic [16:0] r;
        case (idx)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd24109;
            4'd2:    r = 17'd8869;
            4'd3:    r = 17'd3263;
            4'd4:    r = 17'd1200;
            4'd5:    r = 17'd442;
            4'd6:    r = 17'd162;
            4'd7:    r = 17'd60;
            4'd8:    r = 17'd22;
            4'd9:    r = 17'd8;
            4'd10:   r = 17'd3;
            4'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // exp(-n/16), Q1.16.
    function automatic logic [16:0] exp_hi(input logic [3:0] idx);
        logic [16:0] r;
        case (idx)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd61565;
            4'd2:    r = 17'd57835;
            4'd3:    r = 17'd54331;
            4'd4:    r = 17'd51039;
            4'd5:    r = 17'd47947;
            4'd6:    r = 17'd45042;
            4'd7:    r = 17'd42313;
            4'd8:    r = 17'd39750;
            4'd9:    r = 17'd37341;
            4'd10:   r = 17'd35079;
            4'd11:   r = 17'd32954;
            4'd12:   r = 17'd30957;
            4'd13:   r = 17'd29081;
            4'd14:   r = 17'd27319;
            default: r = 17'd25664;
        endcase
        return r;
    endfunction

    // exp(-n/256), Q1.16.
    function automatic logic [16:0] exp_lo(input logic [3:0] idx);
        logic [16:0] r;
        case (idx)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd65280;
            4'd2:    r = 17'd65026;
            4'd3:    r = 17'd64772;
            4'd4:    r = 17'd64520;
            4'd5:    r = 17'd64268;
            4'd6:    r = 17'd64018;
            4'd7:    r = 17'd63768;
            4'd8:    r = 17'd63520;
            4'd9:    r = 17'd63272;
            4'd10:   r = 17'd63025;
            4'd11:   r = 17'd62780;
            4'd12:   r = 17'd62535;
            4'd13:   r = 17'd62291;
            4'd14:   r = 17'd62048;
            default: r = 17'd61806;
        endcase
        return r;
    endfunction

endpackage

/* hdl/rbfplq_div.sv */
// Restoring divider, one quotient bit per cycle.
module rbfplq_div
    import rbfplq_pkg::*;
#(
    parameter int NUM_W = 40,
    parameter int DEN_W = 23
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W:0]   rem_reg;
    logic [NUM_W-1:0] q_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;

    assign trial = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_reg <= trial - {1'b0, den};
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* hdl/rbf_prototype_learn_query_core.sv */
// Top level of the RBF prototype learn and query core.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  in       | input     | in_valid / in_ready    | in_data (in_item_t)
//  out      | output    | out_valid / out_ready  | out_data (out_item_t)
//  cfg      | input     | cfg_we                 | cfg_index, cfg_data
//
// An element that is not the last of a sample is only buffered. A learning sample while
// slots remain is copied into the next free slot. Scoring walks every filled slot through
// the single read port of the prototype memory: distance, gain, two exp steps and weight.
// A learning update then reads, modifies and writes each element of the nearest slot; a
// query accumulates per output element over the filled slots and divides by a nonzero sum.
// After reset no clearing pass runs. in_ready is low while a sample is processed; the last
// result waits in the output register while the next sample's elements are taken.
module rbf_prototype_learn_query_core
    import rbfplq_pkg::*;
#(
    parameter int BASES   = BASES_DEF,
    parameter int IN_DIM  = IN_DIM_DEF,
    parameter int OUT_DIM = OUT_DIM_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SLOT_W = (BASES > 1) ? $clog2(BASES) : 1;
    localparam int CNT_W  = $clog2(BASES + 1);
    localparam int II_W   = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
    localparam int IC_W   = $clog2(IN_DIM + 1);
    localparam int OI_W   = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
    localparam int OC_W   = $clog2(OUT_DIM + 1);
    localparam int MAXD   = (IN_DIM > OUT_DIM) ? IN_DIM : OUT_DIM;
    localparam int E_W    = $clog2(IN_DIM + OUT_DIM + 1);
    localparam int PI_AW  = (BASES * IN_DIM > 1) ? $clog2(BASES * IN_DIM) : 1;
    localparam int PO_AW  = (BASES * OUT_DIM > 1) ? $clog2(BASES * OUT_DIM) : 1;
    localparam int NOUT   = (OUT_DIM < MAX_OUT) ? OUT_DIM : MAX_OUT;
    localparam int DIST_W = 32 + IC_W;
    localparam int PROD_W = DIST_W + 16;
    localparam int X_W    = PROD_W - 24;
    localparam int SUM_W  = 17 + SLOT_W;
    localparam int ACC_W  = 33 + CNT_W;

    state_t state_reg, state_next;

    logic [15:0]        gain_reg, rate_reg;
    logic [CNT_W-1:0]   slots_reg;
    logic [SLOT_W-1:0]  slot_reg, best_slot_reg;
    logic [15:0]        best_w_reg;
    logic [IC_W-1:0]    in_cnt_reg;
    logic [OC_W-1:0]    tg_cnt_reg;
    logic               mode_reg;
    logic [E_W-1:0]     elem_reg;
    logic [CNT_W-1:0]   qk_reg;
    logic [1:0]         qi_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [16:0]        r1_reg;
    logic [3:0]         lo_reg;
    logic               zero_reg;
    logic [15:0]        w_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0] res_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic signed [15:0] smp_in_reg [IN_DIM];
    logic signed [15:0] smp_tg_reg [OUT_DIM];

    logic signed [15:0] pi_mem [BASES*IN_DIM];
    logic signed [15:0] po_mem [BASES*OUT_DIM];
    logic [15:0]        wt_mem [BASES];
    logic signed [15:0] pi_rdata, po_rdata;
    logic [15:0]        wt_rdata;

    logic               pi_we, po_we, wt_we;
    logic [PI_AW-1:0]   pi_addr;
    logic [PO_AW-1:0]   po_addr;
    logic [SLOT_W-1:0]  wt_addr;
    logic signed [15:0] pi_wdata, po_wdata;
    logic [SLOT_W-1:0]  pi_slot, po_slot;
    logic [E_W-1:0]     pi_elem, po_elem;

    logic [E_W-1:0]     sin_idx, stg_idx;
    logic signed [15:0] sin_val, stg_val;

    logic               in_acc, out_load, div_start, div_done;
    logic [ACC_W-1:0]   div_num, div_quot;
    logic               slot_last, qk_end, upd_in;

    logic signed [16:0] dist_diff;
    logic signed [33:0] dist_sq;
    logic [PROD_W-1:0]  x_round;
    logic [X_W-1:0]     x_val;
    logic [33:0]        r1_full;
    logic [33:0]        r2_full;
    logic [17:0]        r2_val;
    logic signed [32:0] q_prod;
    logic signed [16:0] upd_d;
    logic signed [34:0] upd_v;
    logic signed [15:0] upd_p, upd_s, upd_new;
    logic [ACC_W-1:0]   acc_mag;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_load  = (state_reg == S_Q_OUT) && (!out_valid_reg || out_ready);
    assign slot_last = ((CNT_W'(slot_reg) + 1'b1) == slots_reg);
    assign qk_end    = (qk_reg == slots_reg);
    assign upd_in    = (elem_reg < E_W'(IN_DIM));

    // Sample elements that never arrived read as zero.
    always_comb
    begin
        sin_val = '0;
        stg_val = '0;
        if (sin_idx < E_W'(in_cnt_reg))
            sin_val = smp_in_reg[sin_idx[II_W-1:0]];
        if (stg_idx < E_W'(tg_cnt_reg))
            stg_val = smp_tg_reg[stg_idx[OI_W-1:0]];
    end

    always_comb
    begin
        sin_idx = elem_reg;
        stg_idx = elem_reg;
        pi_slot = slot_reg;
        po_slot = best_slot_reg;
        pi_elem = elem_reg;
        po_elem = elem_reg;
        wt_addr = slot_reg;
        case (state_reg)
            S_COPY:
            begin
                pi_slot = slots_reg[SLOT_W-1:0];
                po_slot = slots_reg[SLOT_W-1:0];
            end
            S_DIST:
            begin
                sin_idx = elem_reg - 1'b1;
            end
            S_UPD_RD, S_UPD_WR:
            begin
                pi_slot = best_slot_reg;
                po_elem = elem_reg - E_W'(IN_DIM);
                stg_idx = elem_reg - E_W'(IN_DIM);
            end
            S_Q_ACC:
            begin
                po_slot = qk_reg[SLOT_W-1:0];
                po_elem = E_W'(qi_reg);
                wt_addr = qk_reg[SLOT_W-1:0];
            end
            default:
            begin
            end
        endcase
        pi_addr = PI_AW'(pi_slot) * PI_AW'(IN_DIM) + PI_AW'(pi_elem);
        po_addr = PO_AW'(po_slot) * PO_AW'(OUT_DIM) + PO_AW'(po_elem);
    end

    // Datapath arithmetic.
    always_comb
    begin
        dist_diff = 17'(pi_rdata) - 17'(sin_val);
        dist_sq   = dist_diff * dist_diff;
        x_round   = prod_reg + PROD_W'(1 << 23);
        x_val     = x_round[PROD_W-1:24];
        r1_full   = exp_int(x_val[11:8]) * exp_hi(x_val[7:4]) + 34'd32768;
        r2_full   = r1_reg * exp_lo(lo_reg) + 34'd32768;
        r2_val    = r2_full[33:16];
        q_prod    = $signed({1'b0, wt_rdata}) * po_rdata;
        upd_p     = upd_in ? pi_rdata : po_rdata;
        upd_s     = upd_in ? sin_val : stg_val;
        upd_d     = 17'(upd_s) - 17'(upd_p);
        upd_v     = 35'(upd_d) * 35'($signed({1'b0, rate_reg})) + 35'sd32768;
        upd_new   = upd_p + upd_v[31:16];
        acc_mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        div_num   = acc_mag + ACC_W'(sum_reg >> 1);
    end

    // Next state and memory controls.
    always_comb
    begin
        state_next = state_reg;
        pi_we      = 1'b0;
        po_we      = 1'b0;
        wt_we      = 1'b0;
        pi_wdata   = sin_val;
        po_wdata   = stg_val;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_data.last)
                begin
                    if (in_data.mode)
                        state_next = (slots_reg == '0) ? S_Q_ACC : S_DIST;
                    else if (slots_reg < CNT_W'(BASES))
                        state_next = S_COPY;
                    else
                        state_next = S_DIST;
                end
            end
            S_COPY:
            begin
                pi_we = (elem_reg < E_W'(IN_DIM));
                po_we = (elem_reg < E_W'(OUT_DIM));
                if (elem_reg == E_W'(MAXD - 1))
                    state_next = S_IDLE;
            end
            S_DIST:
            begin
                if (elem_reg == E_W'(IN_DIM))
                    state_next = S_GAIN;
            end
            S_GAIN:   state_next = S_EXP1;
            S_EXP1:   state_next = S_EXP2;
            S_EXP2:   state_next = S_WEIGHT;
            S_WEIGHT:
            begin
                wt_we = 1'b1;
                if (!slot_last)
                    state_next = S_DIST;
                else if (mode_reg)
                    state_next = S_Q_ACC;
                else
                    state_next = S_UPD_RD;
            end
            S_UPD_RD: state_next = S_UPD_WR;
            S_UPD_WR:
            begin
                pi_we    = upd_in;
                po_we    = !upd_in;
                pi_wdata = upd_new;
                po_wdata = upd_new;
                if (elem_reg == E_W'(IN_DIM + OUT_DIM - 1))
                    state_next = S_IDLE;
                else
                    state_next = S_UPD_RD;
            end
            S_Q_ACC:
            begin
                if (sum_reg == '0)
                    state_next = S_Q_OUT;
                else if (qk_end)
                    state_next = S_Q_START;
            end
            S_Q_START:
            begin
                div_start  = 1'b1;
                state_next = S_Q_DIV;
            end
            S_Q_DIV:
            begin
                if (div_done)
                    state_next = S_Q_OUT;
            end
            S_Q_OUT:
            begin
                if (out_load)
                    state_next = (qi_reg == 2'(NOUT - 1)) ? S_IDLE : S_Q_ACC;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (pi_we)
            pi_mem[pi_addr] <= pi_wdata;
        pi_rdata <= pi_mem[pi_addr];
    end

    always_ff @(posedge clk)
    begin
        if (po_we)
            po_mem[po_addr] <= po_wdata;
        po_rdata <= po_mem[po_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wt_we)
            wt_mem[wt_addr] <= w_reg;
        wt_rdata <= wt_mem[wt_addr];
    end

    // Sample buffers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (in_data.is_target)
            begin
                if (tg_cnt_reg < OC_W'(OUT_DIM))
                    smp_tg_reg[tg_cnt_reg[OI_W-1:0]] <= in_data.value;
            end
            else if (in_cnt_reg < IC_W'(IN_DIM))
                smp_in_reg[in_cnt_reg[II_W-1:0]] <= in_data.value;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RESET;
            rate_reg      <= RATE_RESET;
            slots_reg     <= '0;
            best_slot_reg <= '0;
            in_cnt_reg    <= '0;
            tg_cnt_reg    <= '0;
            mode_reg      <= 1'b0;
            elem_reg      <= '0;
            slot_reg      <= '0;
            qk_reg        <= '0;
            qi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_GAIN)
                    gain_reg <= cfg_data;
                else
                    rate_reg <= cfg_data;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (in_acc)
            begin
                if (in_data.is_target && tg_cnt_reg < OC_W'(OUT_DIM))
                    tg_cnt_reg <= tg_cnt_reg + 1'b1;
                if (!in_data.is_target && in_cnt_reg < IC_W'(IN_DIM))
                    in_cnt_reg <= in_cnt_reg + 1'b1;
            end
            if (state_reg != S_IDLE && state_next == S_IDLE)
            begin
                in_cnt_reg <= '0;
                tg_cnt_reg <= '0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    mode_reg <= in_data.mode;
                    elem_reg <= '0;
                    slot_reg <= '0;
                    qk_reg   <= '0;
                    qi_reg   <= '0;
                end
                S_COPY:
                begin
                    elem_reg <= elem_reg + 1'b1;
                    if (state_next == S_IDLE)
                        slots_reg <= slots_reg + 1'b1;
                end
                S_DIST:
                begin
                    elem_reg <= elem_reg + 1'b1;
                end
                S_WEIGHT:
                begin
                    elem_reg <= '0;
                    slot_reg <= slot_reg + 1'b1;
                    if (slot_reg == '0 || w_reg > best_w_reg)
                        best_slot_reg <= slot_reg;
                end
                S_UPD_WR:
                begin
                    elem_reg <= elem_reg + 1'b1;
                end
                S_Q_ACC:
                begin
                    qk_reg <= qk_reg + 1'b1;
                end
                S_Q_OUT:
                begin
                    if (out_load)
                    begin
                        qi_reg <= qi_reg + 1'b1;
                        qk_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                dist_reg <= '0;
                sum_reg  <= '0;
                acc_reg  <= '0;
            end
            S_DIST:
            begin
                if (elem_reg != '0)
                    dist_reg <= dist_reg + DIST_W'(dist_sq[31:0]);
            end
            S_GAIN:
            begin
                prod_reg <= PROD_W'(dist_reg * gain_reg);
            end
            S_EXP1:
            begin
                zero_reg <= (x_val >= X_W'(EXP_LIMIT));
                r1_reg   <= r1_full[32:16];
                lo_reg   <= x_val[3:0];
            end
            S_EXP2:
            begin
                if (zero_reg)
                    w_reg <= '0;
                else if (r2_val > 18'd65535)
                    w_reg <= 16'hFFFF;
                else
                    w_reg <= r2_val[15:0];
            end
            S_WEIGHT:
            begin
                dist_reg <= '0;
                sum_reg  <= sum_reg + SUM_W'(w_reg);
                if (slot_reg == '0 || w_reg > best_w_reg)
                    best_w_reg <= w_reg;
            end
            S_Q_ACC:
            begin
                if (sum_reg == '0)
                    res_reg <= '0;
                else if (qk_reg != '0)
                    acc_reg <= acc_reg + ACC_W'(q_prod);
            end
            S_Q_DIV:
            begin
                if (acc_reg[ACC_W-1])
                    res_reg <= (div_quot > ACC_W'(32768)) ? -16'sd32768
                                                          : 16'(-div_quot);
                else
                    res_reg <= (div_quot > ACC_W'(32767)) ? 16'sd32767 : 16'(div_quot);
            end
            S_Q_OUT:
            begin
                if (out_load)
                begin
                    out_reg.result_value  <= res_reg;
                    out_reg.element_index <= qi_reg;
                    out_reg.result_last   <= (qi_reg == 2'(NOUT - 1));
                    acc_reg               <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    rbfplq_div #(
        .NUM_W (ACC_W),
        .DEN_W (SUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (sum_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slots_reg <= CNT_W'(BASES))
        else $error("slot count beyond the number of bases");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && qi_reg == 2'(NOUT - 1)) |=> (state_reg == S_IDLE))
        else $error("final result item not followed by idle");

    a_weight_slot: assert property (@(posedge clk) disable iff (!rst_n)
        wt_we |-> (CNT_W'(slot_reg) < slots_reg))
        else $error("weight written for an unfilled slot");

    a_div_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (mode_reg && sum_reg != '0))
        else $error("divider started without a query or with a zero sum");

endmodule

/* tb/rbf_prototype_learn_query_checker.sv */
// Checker for the RBF prototype core: predicts query outputs and compares them.
module rbf_prototype_learn_query_checker
    import rbfplq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = BASES_DEF;
    localparam int NI = IN_DIM_DEF;
    localparam int NO = OUT_DIM_DEF;

    logic [15:0] gain_q, rate_q;
    logic signed [15:0] proto_in [NB][NI];
    logic signed [15:0] proto_out [NB][NO];
    logic signed [15:0] smp_in [NI];
    logic signed [15:0] smp_tgt [NO];
    logic [16:0] sim [NB];
    int n_slots, n_in, n_tgt, nearest;
    out_item_t predicted_q [$];

    assign pending = predicted_q.size();

    function automatic logic [16:0] gauss(input longint unsigned sq_sum, input logic [15:0] g);
        longint unsigned x, r;
        x = (sq_sum * g + (64'd1 << 23)) >> 24;
        if (x >= 3072)
            return '0;
        r = (exp_int(x[11:8]) * exp_hi(x[7:4]) + 32768) >> 16;
        r = (r * exp_lo(x[3:0]) + 32768) >> 16;
        return (r > 65535) ? 17'd65535 : r[16:0];
    endfunction

    function automatic logic signed [15:0] nudge(input logic signed [15:0] p,
                                                 input logic signed [15:0] s,
                                                 input logic [15:0] rate);
        longint v, q;
        v = (longint'(s) - longint'(p)) * longint'(rate) + 32768;
        q = (v >= 0) ? (v >>> 16) : -((-v + 65535) >>> 16);
        return 16'(longint'(p) + q);
    endfunction

    // Scores every filled slot; the lowest index wins ties.
    task automatic score_slots(output longint unsigned total);
        longint unsigned sq_sum;
        longint d;
        logic [16:0] top;
        total = 0;
        nearest = 0;
        top = 0;
        for (int j = 0; j < n_slots; j++)
        begin
            sq_sum = 0;
            for (int i = 0; i < NI; i++)
            begin
                d = longint'(proto_in[j][i]) - longint'(smp_in[i]);
                sq_sum += d * d;
            end
            sim[j] = gauss(sq_sum, gain_q);
            total += sim[j];
            if (j == 0 || sim[j] > top)
            begin
                top = sim[j];
                nearest = j;
            end
        end
    endtask

    task automatic absorb_item(input in_item_t it);
        longint unsigned total;
        longint acc, q;
        out_item_t o;
        if (it.is_target)
        begin
            if (n_tgt < NO)
                smp_tgt[n_tgt++] = it.value;
        end
        else if (n_in < NI)
            smp_in[n_in++] = it.value;
        if (!it.last)
            return;
        if (it.mode)
        begin
            score_slots(total);
            for (int e = 0; e < MAX_OUT; e++)
            begin
                q = 0;
                if (total > 0)
                begin
                    acc = 0;
                    for (int j = 0; j < n_slots; j++)
                        acc += longint'(sim[j]) * longint'(proto_out[j][e]);
                    q = ((acc < 0 ? -acc : acc) + longint'(total / 2)) / longint'(total);
                    if (acc < 0)
                        q = -q;
                    if (q > 32767)
                        q = 32767;
                    if (q < -32768)
                        q = -32768;
                end
                o.result_value = 16'(q);
                o.element_index = 2'(e);
                o.result_last = (e == MAX_OUT - 1);
                predicted_q = {predicted_q, o};
            end
        end
        else if (n_slots < NB)
        begin
            for (int i = 0; i < NI; i++)
                proto_in[n_slots][i] = smp_in[i];
            for (int i = 0; i < NO; i++)
                proto_out[n_slots][i] = smp_tgt[i];
            n_slots++;
        end
        else
        begin
            score_slots(total);
            for (int i = 0; i < NI; i++)
                proto_in[nearest][i] = nudge(proto_in[nearest][i], smp_in[i], rate_q);
            for (int i = 0; i < NO; i++)
                proto_out[nearest][i] = nudge(proto_out[nearest][i], smp_tgt[i], rate_q);
        end
        foreach (smp_in[i]) smp_in[i] = '0;
        foreach (smp_tgt[i]) smp_tgt[i] = '0;
        n_in = 0;
        n_tgt = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_q <= GAIN_RESET;
            rate_q <= RATE_RESET;
            n_slots = 0;
            n_in = 0;
            n_tgt = 0;
            fail_count <= 0;
            foreach (smp_in[i]) smp_in[i] = '0;
            foreach (smp_tgt[i]) smp_tgt[i] = '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_GAIN)
                    gain_q <= cfg_data;
                else
                    rate_q <= cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (predicted_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected item %h", out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (out_data !== predicted_q[0])
                    begin
                        if (fail_count < 10)
                            $display("ERROR: expected value %0d idx %0d last %0b, got %0d %0d %0b",
                                predicted_q[0].result_value, predicted_q[0].element_index,
                                predicted_q[0].result_last, out_data.result_value,
                                out_data.element_index, out_data.result_last);
                        fail_count <= fail_count + 1;
                    end
                    void'(predicted_q.pop_front());
                end
            end
            if (in_valid && in_ready)
                absorb_item(in_data);
        end
    end
endmodule

/* tb/rbf_prototype_learn_query_core_test.sv */
// Top of the RBF prototype core testbench: stimulus, configuration and verdict.
module rbf_prototype_learn_query_core_test;
    import rbfplq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    in_item_t in_data;
    out_item_t out_data;
    logic cfg_we, cfg_index;
    logic [15:0] cfg_data;
    int fail_count, pending;
    bit calm;
    int sent;

    rbf_prototype_learn_query_core u_dut (.*);
    rbf_prototype_learn_query_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver stalls in random bursts except during the calm tail.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Valid stays high after the item is taken; the next call or the caller drops it.
    task automatic send_item(input logic m, input logic t, input logic [15:0] v,
                             input logic l);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{mode: m, is_target: t, value: v, last: l};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_value(input logic [15:0] center);
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
            default: return center + 16'($urandom_range(0, 1023)) - 16'd512;
        endcase
    endfunction

    // Inputs then targets; the counts may be short or long.
    task automatic send_sample(input logic m, input logic [15:0] center);
        int ni, nt;
        ni = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10) : 8;
        nt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 4;
        for (int i = 0; i < ni; i++)
            send_item(m, 1'b0, rand_value(center), 1'b0);
        for (int i = 0; i < nt; i++)
            send_item(m, 1'b1, 16'($urandom), 1'b0);
        send_item(m, 1'($urandom_range(0, 1)), rand_value(center), 1'b1);
    endtask

    task automatic drain_and_config(input logic idx, input logic [15:0] data);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20000) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] c;
        logic m;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_GAIN;
        cfg_data = '0;
        calm = 1'b0;
        sent = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // Query with no filled slots gives zeros.
        send_item(1'b1, 1'b0, 16'h1000, 1'b1);
        send_item(1'b0, 1'b0, 16'h7fff, 1'b0);
        send_item(1'b0, 1'b1, 16'h8000, 1'b0);
        send_item(1'b0, 1'b0, 16'h8000, 1'b1);
        send_item(1'b0, 1'b1, 16'h7fff, 1'b1);
        send_item(1'b1, 1'b1, 16'h0123, 1'b0);
        send_item(1'b1, 1'b0, 16'h7fff, 1'b1);
        // Two identical prototypes: tie, then a query far away (zero similarity sum).
        send_item(1'b0, 1'b1, 16'h1000, 1'b1);
        send_item(1'b0, 1'b1, 16'h1000, 1'b1);
        send_item(1'b1, 1'b0, 16'h0000, 1'b1);
        for (int i = 0; i < 8; i++)
            send_item(1'b1, 1'b0, 16'h7fff, i == 7);
        drain_and_config(CFG_GAIN, 16'd0);
        send_item(1'b1, 1'b0, rand_value(16'h0000), 1'b1);
        drain_and_config(CFG_GAIN, 16'hffff);
        send_item(1'b1, 1'b0, rand_value(16'h0000), 1'b1);
        send_item(1'b1, 1'b0, 16'h0000, 1'b1);
        drain_and_config(CFG_GAIN, 16'd256);
        drain_and_config(CFG_RATE, 16'hffff);
        // The first 66 samples fill the remaining slots, with a query now and then.
        for (int k = 0; k < 76; k++)
        begin
            if (k == 69)
                drain_and_config(CFG_RATE, 16'd0);
            if (k == 70)
                calm = 1'b1;
            if (k == 71)
                drain_and_config(CFG_RATE, 16'd6554);
            if (k == 72)
                drain_and_config(CFG_GAIN, 16'd40);
            c = 16'($urandom_range(0, 3)) * 16'h1000 - 16'h1800;
            if (k < 66)
                m = (k % 11 == 10);
            else
                m = 1'($urandom_range(0, 1));
            if (k == 74)
                send_sample(m, c);
            else
                send_item(m, 1'($urandom_range(0, 1)), rand_value(c), 1'b1);
        end
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20000) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
